### src/ipfm_pkg.sv
// ----------------------------------------------------------------------------
// ipfm_pkg
// shared constants, codes and frame tables of the inverter poll frame master
// ----------------------------------------------------------------------------
package ipfm_pkg;

   localparam int NUM_GROUPS  = 6;
   localparam int FRAME_BYTES = 15;

   localparam logic [7:0] CH_ENQ    = 8'h05;
   localparam logic [7:0] CH_EOT    = 8'h04;
   localparam logic [7:0] CH_ACK    = 8'h06;
   localparam logic [7:0] CH_R      = 8'h52;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_HEX_LC = 8'h57;
   localparam logic [7:0] CH_BAD_ID = 8'hFF;

   localparam logic ACT_REQUEST = 1'b0;
   localparam logic ACT_RX      = 1'b1;

   localparam logic KIND_TX      = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [1:0] {
      VERDICT_OK     = 2'd0,
      VERDICT_HEADER = 2'd1,
      VERDICT_PARAM  = 2'd2,
      VERDICT_SUM    = 2'd3
   } verdict_type;

   function automatic logic [7:0] id_digit(input logic [3:0] nib);
      return (nib <= 4'd9) ? (CH_ZERO + {4'd0, nib}) : CH_BAD_ID;
   endfunction

   function automatic logic [7:0] hex_lower(input logic [3:0] nib);
      return (nib < 4'd10) ? (CH_ZERO + {4'd0, nib}) : (CH_HEX_LC + {4'd0, nib});
   endfunction

   function automatic logic [7:0] group_echo(input logic [2:0] grp, input logic [1:0] k);
      logic [31:0] row;
      case (grp)
         3'd0:    row = 32'h30303034;
         3'd1:    row = 32'h30303230;
         3'd2:    row = 32'h30303530;
         3'd3:    row = 32'h30303630;
         3'd4:    row = 32'h30316530;
         3'd5:    row = 32'h30303730;
         default: row = 32'h30303030;
      endcase
      return row[8'(31 - 8 * int'(k)) -: 8];
   endfunction

   function automatic logic [7:0] group_count(input logic [2:0] grp, input logic k);
      logic [15:0] row;
      case (grp)
         3'd0:    row = 16'h3034;
         3'd1:    row = 16'h3032;
         3'd2:    row = 16'h3037;
         3'd3:    row = 16'h3038;
         3'd4:    row = 16'h3033;
         3'd5:    row = 16'h3034;
         default: row = 16'h3030;
      endcase
      return k ? row[7:0] : row[15:8];
   endfunction

   function automatic logic [5:0] group_sum_at(input logic [2:0] grp);
      logic [5:0] n;
      case (grp)
         3'd0:    n = 6'd24;
         3'd1:    n = 6'd16;
         3'd2:    n = 6'd36;
         3'd3:    n = 6'd40;
         3'd4:    n = 6'd20;
         3'd5:    n = 6'd24;
         default: n = 6'd24;
      endcase
      return n;
   endfunction

endpackage

### src/ipfm_req_if.sv
// ----------------------------------------------------------------------------
// ipfm_req_if
// request channel: send command or one received response byte
// ----------------------------------------------------------------------------
interface ipfm_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [2:0] parameter_req;
   logic [7:0] rx_byte;

   modport source (output valid, action, parameter_req, rx_byte, input ready);
   modport sink   (input valid, action, parameter_req, rx_byte, output ready);
endinterface

### src/ipfm_rsp_if.sv
// ----------------------------------------------------------------------------
// ipfm_rsp_if
// result channel: transmit frame bytes and reply verdicts
// ----------------------------------------------------------------------------
interface ipfm_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] tx_byte;
   logic       last;
   logic [1:0] verdict;

   modport source (output valid, kind, tx_byte, last, verdict, input ready);
   modport sink   (input valid, kind, tx_byte, last, verdict, output ready);
endinterface

### src/ipfm_csr_if.sv
// ----------------------------------------------------------------------------
// ipfm_csr_if
// configuration write channel for the station id register
// ----------------------------------------------------------------------------
interface ipfm_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

### src/inverter_poll_frame_master_top.sv
// ----------------------------------------------------------------------------
// inverter_poll_frame_master_top
// master side of an ascii inverter polling link: frame builder and reply check
// ----------------------------------------------------------------------------
// A send command produces a 15-beat request frame on the result channel, one
// beat per cycle while the sink keeps taking them; the input channel is held
// off during beats 1 to 14. A received reply byte is checked in the cycle it
// is accepted, one byte per cycle while the result register can load, and
// the verdict beat comes out of the result register on the next cycle after
// the last checksum character. Stray bytes and unknown groups are taken and
// dropped. The station id may only be written while no frame or reply is open.
module inverter_poll_frame_master_top
   import ipfm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ipfm_req_if.sink    req_chan,
   ipfm_rsp_if.source  rsp_chan,
   ipfm_csr_if.sink    csr_chan
);

   logic [7:0]  station_id_ff;
   logic        awaiting_ff,   awaiting_in;
   logic [2:0]  group_ff,      group_in;
   logic [5:0]  pos_ff,        pos_in;
   logic [15:0] sum_ff,        sum_in;
   logic        hdr_bad_ff,    hdr_bad_in;
   logic        grp_bad_ff,    grp_bad_in;
   logic        sum_bad_ff,    sum_bad_in;
   logic        busy_ff,       busy_in;
   logic [3:0]  tx_idx_ff,     tx_idx_in;

   logic        rsp_valid_ff,  rsp_valid_in;
   logic        rsp_kind_ff,   rsp_kind_in;
   logic [7:0]  rsp_byte_ff,   rsp_byte_in;
   logic        rsp_last_ff,   rsp_last_in;
   verdict_type rsp_verdict_ff, rsp_verdict_in;

   logic        out_load;
   logic        req_fire;
   logic        req_go;
   logic        rx_go;
   logic [7:0]  id_hi;
   logic [7:0]  id_lo;
   logic [15:0] frame_sum;
   logic [7:0]  frame_byte;
   logic [5:0]  sum_at;
   logic [5:0]  sum_ofs;
   logic [3:0]  sum_nib;
   logic        verdict_fire;
   verdict_type verdict_val;

   assign csr_chan.ready = 1'b1;

   assign out_load       = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !busy_ff && out_load;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign req_go = req_fire && (req_chan.action == ACT_REQUEST)
                   && (req_chan.parameter_req < 3'(NUM_GROUPS));
   assign rx_go  = req_fire && (req_chan.action == ACT_RX) && awaiting_ff;

   assign id_hi = id_digit(station_id_ff[7:4]);
   assign id_lo = id_digit(station_id_ff[3:0]);

   // frame sum over bytes 1..9 of the frame being sent
   assign frame_sum = 16'(id_hi) + 16'(id_lo) + 16'(CH_R)
                    + 16'(group_echo(group_ff, 2'd0)) + 16'(group_echo(group_ff, 2'd1))
                    + 16'(group_echo(group_ff, 2'd2)) + 16'(group_echo(group_ff, 2'd3))
                    + 16'(group_count(group_ff, 1'b0)) + 16'(group_count(group_ff, 1'b1));

   always_comb begin
      case (tx_idx_ff)
         4'd0:    frame_byte = CH_ENQ;
         4'd1:    frame_byte = id_hi;
         4'd2:    frame_byte = id_lo;
         4'd3:    frame_byte = CH_R;
         4'd4:    frame_byte = group_echo(group_ff, 2'd0);
         4'd5:    frame_byte = group_echo(group_ff, 2'd1);
         4'd6:    frame_byte = group_echo(group_ff, 2'd2);
         4'd7:    frame_byte = group_echo(group_ff, 2'd3);
         4'd8:    frame_byte = group_count(group_ff, 1'b0);
         4'd9:    frame_byte = group_count(group_ff, 1'b1);
         4'd10:   frame_byte = hex_lower(frame_sum[15:12]);
         4'd11:   frame_byte = hex_lower(frame_sum[11:8]);
         4'd12:   frame_byte = hex_lower(frame_sum[7:4]);
         4'd13:   frame_byte = hex_lower(frame_sum[3:0]);
         default: frame_byte = CH_EOT;
      endcase
   end

   // reply byte check
   assign sum_at  = group_sum_at(group_ff);
   assign sum_ofs = pos_ff - sum_at;

   always_comb begin
      case (sum_ofs[1:0])
         2'd0:    sum_nib = sum_ff[15:12];
         2'd1:    sum_nib = sum_ff[11:8];
         2'd2:    sum_nib = sum_ff[7:4];
         default: sum_nib = sum_ff[3:0];
      endcase
   end

   always_comb begin
      hdr_bad_in = hdr_bad_ff;
      grp_bad_in = grp_bad_ff;
      sum_bad_in = sum_bad_ff;
      sum_in     = sum_ff;
      if (pos_ff == 6'd0 && req_chan.rx_byte != CH_ACK) hdr_bad_in = 1'b1;
      if (pos_ff == 6'd1 && req_chan.rx_byte != id_hi)  hdr_bad_in = 1'b1;
      if (pos_ff == 6'd2 && req_chan.rx_byte != id_lo)  hdr_bad_in = 1'b1;
      if (pos_ff == 6'd3 && req_chan.rx_byte != CH_R)   hdr_bad_in = 1'b1;
      if (pos_ff >= 6'd4 && pos_ff <= 6'd7
          && req_chan.rx_byte != group_echo(group_ff, pos_ff[1:0])) begin
         grp_bad_in = 1'b1;
      end
      if (pos_ff >= 6'd1 && pos_ff < sum_at) sum_in = sum_ff + 16'(req_chan.rx_byte);
      if (pos_ff >= sum_at && pos_ff <= sum_at + 6'd3
          && req_chan.rx_byte != hex_lower(sum_nib)) begin
         sum_bad_in = 1'b1;
      end
      verdict_fire = (pos_ff == sum_at + 6'd3);
      if (hdr_bad_in)      verdict_val = VERDICT_HEADER;
      else if (grp_bad_in) verdict_val = VERDICT_PARAM;
      else if (sum_bad_in) verdict_val = VERDICT_SUM;
      else                 verdict_val = VERDICT_OK;
   end

   always_comb begin
      awaiting_in    = awaiting_ff;
      group_in       = group_ff;
      pos_in         = pos_ff;
      busy_in        = busy_ff;
      tx_idx_in      = tx_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_verdict_in = rsp_verdict_ff;
      if (busy_ff && out_load) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = KIND_TX;
         rsp_byte_in    = frame_byte;
         rsp_last_in    = (tx_idx_ff == 4'(FRAME_BYTES - 1));
         rsp_verdict_in = VERDICT_OK;
         tx_idx_in      = tx_idx_ff + 4'd1;
         busy_in        = (tx_idx_ff != 4'(FRAME_BYTES - 1));
      end else if (req_go) begin
         rsp_valid_in   = 1'b1;
         rsp_kind_in    = KIND_TX;
         rsp_byte_in    = CH_ENQ;
         rsp_last_in    = 1'b0;
         rsp_verdict_in = VERDICT_OK;
         tx_idx_in      = 4'd1;
         busy_in        = 1'b1;
         awaiting_in    = 1'b1;
         group_in       = req_chan.parameter_req;
         pos_in         = 6'd0;
      end else if (rx_go) begin
         if (verdict_fire) begin
            rsp_valid_in   = 1'b1;
            rsp_kind_in    = KIND_VERDICT;
            rsp_byte_in    = 8'd0;
            rsp_last_in    = 1'b1;
            rsp_verdict_in = verdict_val;
            awaiting_in    = 1'b0;
            pos_in         = 6'd0;
         end else begin
            pos_in = pos_ff + 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         station_id_ff <= 8'h01;
         awaiting_ff   <= 1'b0;
         group_ff      <= 3'd0;
         pos_ff        <= 6'd0;
         sum_ff        <= 16'd0;
         hdr_bad_ff    <= 1'b0;
         grp_bad_ff    <= 1'b0;
         sum_bad_ff    <= 1'b0;
         busy_ff       <= 1'b0;
         tx_idx_ff     <= 4'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_chan.valid && csr_chan.ready) station_id_ff <= csr_chan.data;
         awaiting_ff  <= awaiting_in;
         group_ff     <= group_in;
         pos_ff       <= pos_in;
         busy_ff      <= busy_in;
         tx_idx_ff    <= tx_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_go) begin
            sum_ff     <= 16'd0;
            hdr_bad_ff <= 1'b0;
            grp_bad_ff <= 1'b0;
            sum_bad_ff <= 1'b0;
         end else if (rx_go) begin
            sum_ff     <= sum_in;
            hdr_bad_ff <= hdr_bad_in;
            grp_bad_ff <= grp_bad_in;
            sum_bad_ff <= sum_bad_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff    <= rsp_kind_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_verdict_ff <= rsp_verdict_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.kind    = rsp_kind_ff;
   assign rsp_chan.tx_byte = rsp_byte_ff;
   assign rsp_chan.last    = rsp_last_ff;
   assign rsp_chan.verdict = rsp_verdict_ff;

   a_verdict_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == KIND_VERDICT |-> rsp_last_ff)
      else $error("verdict beat without last");

   a_request_opens_reply: assert property (@(posedge clock) disable iff (reset)
      req_go |=> awaiting_ff && busy_ff && pos_ff == 6'd0)
      else $error("request did not open reply check");

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= 6'd43)
      else $error("reply byte position out of range");

   a_no_verdict_while_sending: assert property (@(posedge clock) disable iff (reset)
      busy_ff && rsp_valid_ff |-> rsp_kind_ff == KIND_TX)
      else $error("verdict beat inside request frame");

endmodule

### bench/inverter_poll_frame_master_checker.sv
// ----------------------------------------------------------------------------
// inverter_poll_frame_master_checker
// Watches the request, result and station id channels of the poll frame
// master. It keeps its own copy of the link state, works out the frame beats
// and reply verdicts that each accepted request beat must produce, and
// compares every result beat field by field against the oldest one due.
// ----------------------------------------------------------------------------
module inverter_poll_frame_master_checker
   import ipfm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ipfm_req_if  req_chan,
   ipfm_rsp_if  rsp_chan,
   ipfm_csr_if  csr_chan,
   output int   fail_count,
   output int   pending,
   output logic reply_open
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        last;
      verdict_type verdict;
   } link_beat_type;

   link_beat_type due_beats[$];
   logic [7:0]  station;
   logic        awaiting;
   logic [2:0]  held_group;
   logic [5:0]  position;
   logic [15:0] reply_sum;
   logic        hdr_err;
   logic        grp_err;
   logic        sum_err;
   int          beat_count = 0;
   int          fault_total = 0;

   function automatic logic [7:0] digit_char(input logic [3:0] nib);
      return (nib > 4'd9) ? CH_BAD_ID : CH_ZERO + {4'h0, nib};
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      return (nib > 4'd9) ? CH_HEX_LC + {4'h0, nib} : CH_ZERO + {4'h0, nib};
   endfunction

   function automatic logic [31:0] echo_text(input logic [2:0] grp);
      case (grp)
         3'd0:    return "0004";
         3'd1:    return "0020";
         3'd2:    return "0050";
         3'd3:    return "0060";
         3'd4:    return "01e0";
         default: return "0070";
      endcase
   endfunction

   function automatic logic [15:0] count_text(input logic [2:0] grp);
      case (grp)
         3'd0:    return "04";
         3'd1:    return "02";
         3'd2:    return "07";
         3'd3:    return "08";
         3'd4:    return "03";
         default: return "04";
      endcase
   endfunction

   function automatic int sum_start(input logic [2:0] grp);
      case (grp)
         3'd0:    return 24;
         3'd1:    return 16;
         3'd2:    return 36;
         3'd3:    return 40;
         3'd4:    return 20;
         default: return 24;
      endcase
   endfunction

   function automatic void note_fault(input string msg);
      if (fault_total < 10) $display("%s", msg);
      fault_total++;
   endfunction

   task automatic predict_link(input logic act, input logic [2:0] grp, input logic [7:0] rx);
      logic [7:0]    frame [15];
      logic [31:0]   echo;
      logic [15:0]   count;
      logic [15:0]   s;
      link_beat_type b;
      verdict_type   v;
      int            p;
      int            n;
      if (act == ACT_REQUEST) begin
         if (grp <= 3'd5) begin
            echo = echo_text(grp);
            count = count_text(grp);
            frame[0] = CH_ENQ;
            frame[1] = digit_char(station[7:4]);
            frame[2] = digit_char(station[3:0]);
            frame[3] = CH_R;
            for (int i = 0; i < 4; i++) frame[4 + i] = echo[31 - 8 * i -: 8];
            frame[8] = count[15:8];
            frame[9] = count[7:0];
            s = '0;
            for (int i = 1; i < 10; i++) s = s + frame[i];
            for (int i = 0; i < 4; i++) frame[10 + i] = hex_char(s[15 - 4 * i -: 4]);
            frame[14] = CH_EOT;
            for (int i = 0; i < 15; i++) begin
               b.kind = KIND_TX;
               b.tx_byte = frame[i];
               b.last = (i == 14);
               b.verdict = VERDICT_OK;
               due_beats.push_back(b);
            end
            awaiting = 1'b1;
            held_group = grp;
            position = '0;
            reply_sum = '0;
            hdr_err = 1'b0;
            grp_err = 1'b0;
            sum_err = 1'b0;
         end
      end else if (awaiting) begin
         p = position;
         n = sum_start(held_group);
         echo = echo_text(held_group);
         if (p == 0 && rx != CH_ACK) hdr_err = 1'b1;
         if (p == 1 && rx != digit_char(station[7:4])) hdr_err = 1'b1;
         if (p == 2 && rx != digit_char(station[3:0])) hdr_err = 1'b1;
         if (p == 3 && rx != CH_R) hdr_err = 1'b1;
         if (p >= 4 && p <= 7 && rx != echo[31 - 8 * (p - 4) -: 8]) grp_err = 1'b1;
         if (p >= 1 && p < n) reply_sum = reply_sum + rx;
         if (p >= n && p <= n + 3 && rx != hex_char(reply_sum[15 - 4 * (p - n) -: 4]))
            sum_err = 1'b1;
         if (p == n + 3) begin
            v = hdr_err ? VERDICT_HEADER : grp_err ? VERDICT_PARAM :
                sum_err ? VERDICT_SUM : VERDICT_OK;
            b.kind = KIND_VERDICT;
            b.tx_byte = 8'h00;
            b.last = 1'b1;
            b.verdict = v;
            due_beats.push_back(b);
            awaiting = 1'b0;
            position = '0;
         end else begin
            position = position + 6'd1;
         end
      end
   endtask

   task automatic check_beat();
      link_beat_type want;
      beat_count++;
      if (due_beats.size() == 0) begin
         note_fault($sformatf("beat %0d: unexpected kind %0d byte %02h last %0d verdict %0d",
                              beat_count, rsp_chan.kind, rsp_chan.tx_byte, rsp_chan.last,
                              rsp_chan.verdict));
      end else begin
         want = due_beats.pop_front();
         if (rsp_chan.kind !== want.kind || rsp_chan.tx_byte !== want.tx_byte ||
             rsp_chan.last !== want.last || rsp_chan.verdict !== want.verdict)
            note_fault($sformatf({"beat %0d: expected kind %0d byte %02h last %0d verdict %0d,",
                                  " got kind %0d byte %02h last %0d verdict %0d"},
                                 beat_count, want.kind, want.tx_byte, want.last, want.verdict,
                                 rsp_chan.kind, rsp_chan.tx_byte, rsp_chan.last,
                                 rsp_chan.verdict));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         station = 8'h01;
         awaiting = 1'b0;
         held_group = '0;
         position = '0;
         reply_sum = '0;
         hdr_err = 1'b0;
         grp_err = 1'b0;
         sum_err = 1'b0;
         due_beats.delete();
      end else begin
         if (csr_chan.valid === 1'b1 && csr_chan.ready === 1'b1) station = csr_chan.data;
         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1)
            predict_link(req_chan.action, req_chan.parameter_req, req_chan.rx_byte);
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) check_beat();
      end
      fail_count <= fault_total;
      pending <= due_beats.size();
      reply_open <= awaiting;
   end

endmodule

### bench/inverter_poll_frame_master_top_tb.sv
// ----------------------------------------------------------------------------
// inverter_poll_frame_master_top_tb
// Drives request frames and reply byte streams into the poll frame master
// under several station ids, with random gaps on both channels and one long
// result stall. Under half of the replies are well formed with random data;
// the rest carry header, echo or checksum faults, interruptions or noise. A
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module inverter_poll_frame_master_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ipfm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_GOAL   = 450;
   localparam int PHASES      = 8;

   typedef enum int {
      REPLY_CLEAN,
      REPLY_BAD_HEADER,
      REPLY_BAD_ECHO,
      REPLY_BAD_SUM,
      REPLY_MANY_FAULTS,
      REPLY_INTERRUPTED,
      REPLY_ABANDONED,
      REPLY_NOISE
   } reply_shape_type;

   logic       clock;
   logic       reset;
   int         fail_count;
   int         pending;
   logic       reply_open;
   int         items_sent = 0;
   bit         req_idle = 1'b1;
   bit         rsp_idle = 1'b1;
   bit         rsp_hold = 1'b0;
   logic [7:0] station_now = 8'h01;

   ipfm_req_if req_chan ();
   ipfm_rsp_if rsp_chan ();
   ipfm_csr_if csr_chan ();

   inverter_poll_frame_master_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   inverter_poll_frame_master_checker link_check (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_chan   (csr_chan),
      .fail_count (fail_count),
      .pending    (pending),
      .reply_open (reply_open)
   );

   function automatic logic [7:0] ascii_digit(input logic [3:0] nib);
      return (nib > 4'd9) ? CH_BAD_ID : CH_ZERO + {4'h0, nib};
   endfunction

   function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
      return (nib > 4'd9) ? CH_HEX_LC + {4'h0, nib} : CH_ZERO + {4'h0, nib};
   endfunction

   function automatic logic [31:0] reply_echo(input logic [2:0] grp);
      case (grp)
         3'd0:    return "0004";
         3'd1:    return "0020";
         3'd2:    return "0050";
         3'd3:    return "0060";
         3'd4:    return "01e0";
         default: return "0070";
      endcase
   endfunction

   function automatic int reply_sum_at(input logic [2:0] grp);
      case (grp)
         3'd0:    return 24;
         3'd1:    return 16;
         3'd2:    return 36;
         3'd3:    return 40;
         3'd4:    return 20;
         default: return 24;
      endcase
   endfunction

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_item(input logic act, input logic [2:0] grp, input logic [7:0] rx,
                            input bit counted);
      int gap;
      gap = req_idle ? $urandom_range(0, 11) : 0;
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= act;
      req_chan.parameter_req <= grp;
      req_chan.rx_byte <= rx;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (counted) items_sent++;
   endtask

   task automatic settle_link();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (reply_open) begin
         send_item(ACT_RX, 3'($urandom), 8'($urandom), 1'b0);
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      wait (pending == 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_station(input logic [7:0] id);
      settle_link();
      csr_chan.valid <= 1'b1;
      csr_chan.data <= id;
      do @(posedge clock); while (csr_chan.ready !== 1'b1);
      csr_chan.valid <= 1'b0;
      station_now = id;
   endtask

   task automatic send_reply(input logic [2:0] grp, input reply_shape_type shape);
      logic [7:0]  reply [44];
      logic [31:0] echo;
      logic [15:0] s;
      int          n;
      int          k;
      int          cut;
      n = reply_sum_at(grp);
      echo = reply_echo(grp);
      reply[0] = CH_ACK;
      reply[1] = ascii_digit(station_now[7:4]);
      reply[2] = ascii_digit(station_now[3:0]);
      reply[3] = CH_R;
      for (int i = 0; i < 4; i++) reply[4 + i] = echo[31 - 8 * i -: 8];
      for (int i = 8; i < n; i++) reply[i] = 8'($urandom);
      if (shape == REPLY_BAD_HEADER) begin
         k = $urandom_range(0, 3);
         reply[k] = reply[k] ^ 8'($urandom_range(1, 255));
      end else if (shape == REPLY_BAD_ECHO) begin
         k = $urandom_range(4, 7);
         reply[k] = reply[k] ^ 8'($urandom_range(1, 255));
      end
      s = '0;
      for (int i = 1; i < n; i++) s = s + reply[i];
      for (int i = 0; i < 4; i++) reply[n + i] = ascii_hex(s[15 - 4 * i -: 4]);
      if (shape == REPLY_BAD_SUM) begin
         k = n + $urandom_range(0, 3);
         reply[k] = reply[k] ^ 8'($urandom_range(1, 255));
      end else if (shape == REPLY_MANY_FAULTS) begin
         repeat (3) begin
            k = $urandom_range(0, n + 3);
            reply[k] = reply[k] ^ 8'($urandom_range(1, 255));
         end
      end else if (shape == REPLY_NOISE) begin
         for (int i = 0; i < n + 4; i++) reply[i] = 8'($urandom);
      end
      cut = (shape == REPLY_INTERRUPTED || shape == REPLY_ABANDONED) ?
            $urandom_range(0, n + 3) : n + 4;
      for (int i = 0; i < n + 4; i++) begin
         if (i == cut) begin
            if (shape == REPLY_ABANDONED) break;
            send_item(ACT_REQUEST, 3'($urandom_range(6, 7)), 8'($urandom), 1'b0);
         end
         send_item(ACT_RX, 3'($urandom), reply[i], 1'b1);
      end
   endtask

   task automatic run_sequence();
      int              pick;
      logic [2:0]      grp;
      reply_shape_type shape;
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         send_item(ACT_REQUEST, 3'($urandom_range(6, 7)), 8'($urandom), 1'b0);
      end else if (pick == 1) begin
         repeat ($urandom_range(1, 3)) send_item(ACT_RX, 3'($urandom), 8'($urandom), 1'b0);
      end else begin
         if ($urandom_range(0, 1) == 1) grp = 3'($urandom_range(0, 5));
         else grp = ($urandom_range(0, 1) == 1) ? 3'd1 : 3'd4;
         pick = $urandom_range(0, 10);
         shape = (pick < 4) ? REPLY_CLEAN : reply_shape_type'(pick - 3);
         send_item(ACT_REQUEST, grp, 8'($urandom), 1'b1);
         send_reply(grp, shape);
      end
   endtask

   // result side: random stalls per beat while rsp_idle is set, plus a long hold-off while hold is set
   initial begin
      int rsp_gap;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      forever begin
         rsp_gap = rsp_idle ? $urandom_range(0, 11) : 0;
         if (rsp_gap != 0 || rsp_hold) begin
            rsp_chan.ready <= 1'b0;
            repeat (rsp_gap) @(posedge clock);
            while (rsp_hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (rsp_chan.valid !== 1'b1);
      end
   end

   initial begin
      wait (items_sent >= 120);
      @(negedge clock);
      rsp_hold = 1'b1;
      repeat (400) @(negedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("inverter_poll_frame_master_top_tb NOT OK");
      $finish;
   end

   initial begin
      logic [7:0] next_id;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.action <= ACT_REQUEST;
      req_chan.parameter_req <= 3'd0;
      req_chan.rx_byte <= 8'h00;
      csr_chan.valid <= 1'b0;
      csr_chan.data <= 8'h00;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // stray bytes, unknown groups, every group, then one clean pv reply
      send_item(ACT_RX, 3'd0, 8'h00, 1'b0);
      send_item(ACT_RX, 3'd7, 8'hFF, 1'b0);
      send_item(ACT_REQUEST, 3'd6, 8'h00, 1'b0);
      send_item(ACT_REQUEST, 3'd7, 8'hFF, 1'b0);
      for (int k = 0; k < 6; k++) send_item(ACT_REQUEST, 3'((k + 2) % 6), 8'($urandom), 1'b1);
      send_reply(3'd1, REPLY_CLEAN);

      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph != 0) begin
            case (ph)
               1:       next_id = 8'h00;
               2:       next_id = 8'h99;
               3:       next_id = 8'hFF;
               4:       next_id = 8'h5A;
               5:       next_id = 8'hA9;
               6:       next_id = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
               default: next_id = 8'($urandom);
            endcase
            write_station(next_id);
         end
         req_idle = ($urandom_range(0, 2) != 0);
         rsp_idle = ($urandom_range(0, 2) != 0);
         while (items_sent < ITEM_GOAL * (ph + 1) / PHASES) run_sequence();
      end

      req_chan.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("inverter_poll_frame_master_top_tb OK");
      end else begin
         $display("inverter_poll_frame_master_top_tb NOT OK");
      end
      $finish;
   end

endmodule
